// ===== hw/rtl/tfc_pkg.sv =====
// Shared types, register indexes and reset constants for the trouble flash-code LED block.
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned CodeW = 3;
  localparam int unsigned IdxW  = 2;

  localparam logic [TimeW-1:0] ON_TIME_RST    = 16'd500;
  localparam logic [TimeW-1:0] GAP_TIME_RST   = 16'd250;
  localparam logic [TimeW-1:0] PAUSE_TIME_RST = 16'd10000;

  typedef enum logic [IdxW-1:0] {
    REG_ON_TIME    = 2'd0,
    REG_GAP_TIME   = 2'd1,
    REG_PAUSE_TIME = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_ON    = 2'd0,
    SEL_GAP   = 2'd1,
    SEL_PAUSE = 2'd2
  } sel_t;

  typedef struct packed {
    logic any_trouble;
    logic heat_det_one;
    logic heat_det_two;
    logic manual_switch;
    logic actuator_fault;
    logic primary_power;
    logic secondary_power;
    logic pressure_switch;
  } flags_t;

  typedef struct packed {
    logic [TimeW-1:0] on_time;
    logic [TimeW-1:0] gap_time;
    logic [TimeW-1:0] pause_time;
  } cfg_t;

  typedef struct packed {
    logic             led_on;
    logic             buzzer_flag;
    logic [CodeW-1:0] trouble_code;
  } result_t;

endpackage

// ===== hw/rtl/trouble_flash_code_led.sv =====
// Top level of the trouble flash-code LED generator: ports, registers, word staging.
//
// Each input word is one millisecond tick carrying the trouble flags. Every accepted
// word produces exactly one result word: the LED drive level, the buzzer flag and
// the latched trouble code after that tick.
// Both channels use valid and stall; a word moves at a rising edge with valid high
// and stall low. The input word is captured in an input register, the tick update
// runs between that register and the output register, and the result of a word is
// presented from the output register once both registers have advanced past it.
// One word is taken every cycle while the output side is not stalled; the rate is
// set by the single update stage.
// When the receiver stalls with a result waiting, the output register and the input
// register hold and in_stall is raised until the result is taken.
// Configuration writes on cfg_we, cfg_index and cfg_data are taken at once and
// should be made only while no word is in flight; an index beyond the last register
// is ignored.
// Synchronous reset loads on time 500, gap time 250 and pause time 10000, clears the
// sequencer state and empties both registers.
`timescale 1ns / 1ps

module trouble_flash_code_led (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_any_trouble,
  input  logic                      in_heat_det_one,
  input  logic                      in_heat_det_two,
  input  logic                      in_manual_switch,
  input  logic                      in_actuator_fault,
  input  logic                      in_primary_power,
  input  logic                      in_secondary_power,
  input  logic                      in_pressure_switch,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_led_on,
  output logic                      out_buzzer_flag,
  output logic [tfc_pkg::CodeW-1:0] out_trouble_code,
  input  logic                      cfg_we,
  input  logic [tfc_pkg::IdxW-1:0]  cfg_index,
  input  logic [tfc_pkg::TimeW-1:0] cfg_data
);
  import tfc_pkg::*;

  cfg_t    cfg_r;
  flags_t  flags_r;
  logic    in_valid_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time    <= ON_TIME_RST;
      cfg_r.gap_time   <= GAP_TIME_RST;
      cfg_r.pause_time <= PAUSE_TIME_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ON_TIME:    cfg_r.on_time    <= cfg_data;
        REG_GAP_TIME:   cfg_r.gap_time   <= cfg_data;
        REG_PAUSE_TIME: cfg_r.pause_time <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r  <= in_valid;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_r.any_trouble     <= in_any_trouble;
      flags_r.heat_det_one    <= in_heat_det_one;
      flags_r.heat_det_two    <= in_heat_det_two;
      flags_r.manual_switch   <= in_manual_switch;
      flags_r.actuator_fault  <= in_actuator_fault;
      flags_r.primary_power   <= in_primary_power;
      flags_r.secondary_power <= in_secondary_power;
      flags_r.pressure_switch <= in_pressure_switch;
      out_r                   <= res;
    end
  end

  tfc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv && in_valid_r),
    .flags (flags_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid        = out_valid_r;
  assign out_led_on       = out_r.led_on;
  assign out_buzzer_flag  = out_r.buzzer_flag;
  assign out_trouble_code = out_r.trouble_code;

endmodule

// ===== hw/rtl/tfc_engine.sv =====
// Flash sequencer state and the per-tick update of LED, buzzer and latched code.
`timescale 1ns / 1ps

module tfc_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  tfc_pkg::flags_t  flags,
  input  tfc_pkg::cfg_t    cfg,
  output tfc_pkg::result_t res
);
  import tfc_pkg::*;

  logic             led_r, led_nxt;
  logic [CodeW-1:0] flash_cnt_r, flash_cnt_nxt;
  sel_t             sel_r, sel_nxt;
  logic [TimeW-1:0] elapsed_r, elapsed_nxt;
  logic             buzzer_r, buzzer_nxt;
  logic [CodeW-1:0] code_r, code_nxt;

  logic [TimeW-1:0] elapsed_inc;
  logic [TimeW-1:0] interval;
  logic [CodeW-1:0] enc;
  logic [CodeW-1:0] code;

  always_comb begin
    if (flags.heat_det_one) begin
      enc = 3'd1;
    end else if (flags.heat_det_two) begin
      enc = 3'd2;
    end else if (flags.manual_switch) begin
      enc = 3'd3;
    end else if (flags.actuator_fault) begin
      enc = 3'd4;
    end else if (flags.primary_power) begin
      enc = 3'd5;
    end else if (flags.secondary_power) begin
      enc = 3'd6;
    end else if (flags.pressure_switch) begin
      enc = 3'd7;
    end else begin
      enc = 3'd0;
    end
  end

  always_comb begin
    case (sel_r)
      SEL_GAP:   interval = cfg.gap_time;
      SEL_PAUSE: interval = cfg.pause_time;
      default:   interval = cfg.on_time;
    endcase
  end

  assign elapsed_inc = (elapsed_r != {TimeW{1'b1}}) ? elapsed_r + 1'b1 : elapsed_r;
  assign code        = flags.any_trouble ? enc : '0;

  always_comb begin
    led_nxt       = led_r;
    flash_cnt_nxt = flash_cnt_r;
    sel_nxt       = sel_r;
    elapsed_nxt   = elapsed_inc;
    buzzer_nxt    = buzzer_r;
    code_nxt      = code_r;
    if (!flags.any_trouble) begin
      code_nxt = '0;
    end else if (code != '0) begin
      code_nxt = code;
    end
    if (code == '0) begin
      flash_cnt_nxt = '0;
      sel_nxt       = SEL_GAP;
    end else if (elapsed_inc >= interval) begin
      if (flash_cnt_r < code) begin
        if (led_r) begin
          sel_nxt = SEL_GAP;
        end else begin
          sel_nxt       = SEL_ON;
          flash_cnt_nxt = flash_cnt_r + 1'b1;
        end
        buzzer_nxt = 1'b0;
      end else begin
        flash_cnt_nxt = '0;
        sel_nxt       = SEL_PAUSE;
        buzzer_nxt    = 1'b1;
      end
      led_nxt     = ~led_r;
      elapsed_nxt = '0;
    end
  end

  always_comb begin
    res.led_on       = (code != '0) ? led_nxt : 1'b0;
    res.buzzer_flag  = buzzer_nxt;
    res.trouble_code = code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r       <= 1'b0;
      flash_cnt_r <= '0;
      sel_r       <= SEL_ON;
      elapsed_r   <= '0;
      buzzer_r    <= 1'b0;
      code_r      <= '0;
    end else if (step) begin
      led_r       <= led_nxt;
      flash_cnt_r <= flash_cnt_nxt;
      sel_r       <= sel_nxt;
      elapsed_r   <= elapsed_nxt;
      buzzer_r    <= buzzer_nxt;
      code_r      <= code_nxt;
    end
  end

endmodule

// ===== sim/flash_code_monitor.sv =====
// Channel monitor for the trouble flash-code LED block: predicts every result word and compares.
`timescale 1ns / 1ps

module flash_code_monitor (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  tfc_pkg::flags_t           in_word,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  tfc_pkg::result_t          out_word,
  input  logic                      cfg_we,
  input  logic [tfc_pkg::IdxW-1:0]  cfg_index,
  input  logic [tfc_pkg::TimeW-1:0] cfg_data,
  output int                        mismatches,
  output int                        pending
);
  import tfc_pkg::*;

  logic [TimeW-1:0] on_ms;
  logic [TimeW-1:0] gap_ms;
  logic [TimeW-1:0] pause_ms;

  logic             led_level;
  logic [CodeW-1:0] flashes;
  sel_t             interval;
  logic [TimeW-1:0] elapsed;
  logic             buzzer;
  logic [CodeW-1:0] shown_code;

  result_t          predicted_words[$];
  result_t          want;

  function automatic result_t advance_tick(input flags_t f);
    logic [CodeW-1:0] code;
    logic [TimeW-1:0] limit;
    result_t          r;
    if (elapsed != {TimeW{1'b1}}) elapsed = elapsed + 1'b1;
    code = '0;
    if (f.any_trouble) begin
      if (f.heat_det_one) code = 3'd1;
      else if (f.heat_det_two) code = 3'd2;
      else if (f.manual_switch) code = 3'd3;
      else if (f.actuator_fault) code = 3'd4;
      else if (f.primary_power) code = 3'd5;
      else if (f.secondary_power) code = 3'd6;
      else if (f.pressure_switch) code = 3'd7;
    end
    if (!f.any_trouble) shown_code = '0;
    else if (code != '0) shown_code = code;
    if (code == '0) begin
      flashes  = '0;
      interval = SEL_GAP;
      r.led_on = 1'b0;
    end else begin
      case (interval)
        SEL_GAP:   limit = gap_ms;
        SEL_PAUSE: limit = pause_ms;
        default:   limit = on_ms;
      endcase
      if (elapsed >= limit) begin
        if (flashes < code) begin
          if (led_level) begin
            interval = SEL_GAP;
          end else begin
            interval = SEL_ON;
            flashes  = flashes + 1'b1;
          end
          buzzer = 1'b0;
        end else begin
          flashes  = '0;
          interval = SEL_PAUSE;
          buzzer   = 1'b1;
        end
        led_level = ~led_level;
        elapsed   = '0;
      end
      r.led_on = led_level;
    end
    r.buzzer_flag  = buzzer;
    r.trouble_code = shown_code;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      on_ms      = ON_TIME_RST;
      gap_ms     = GAP_TIME_RST;
      pause_ms   = PAUSE_TIME_RST;
      led_level  = 1'b0;
      flashes    = '0;
      interval   = SEL_ON;
      elapsed    = '0;
      buzzer     = 1'b0;
      shown_code = '0;
      predicted_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ON_TIME:    on_ms    = cfg_data;
          REG_GAP_TIME:   gap_ms   = cfg_data;
          REG_PAUSE_TIME: pause_ms = cfg_data;
          default:        ;
        endcase
      end
      if (in_valid && !in_stall) predicted_words.push_back(advance_tick(in_word));
      if (out_valid && !out_stall) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected word led_on %0b buzzer_flag %0b trouble_code %0d",
                   $time, out_word.led_on, out_word.buzzer_flag, out_word.trouble_code);
          mismatches++;
        end else begin
          want = predicted_words.pop_front();
          if (out_word.led_on !== want.led_on) begin
            $display("%0t: led_on expected %0b, got %0b", $time, want.led_on, out_word.led_on);
            mismatches++;
          end
          if (out_word.buzzer_flag !== want.buzzer_flag) begin
            $display("%0t: buzzer_flag expected %0b, got %0b",
                     $time, want.buzzer_flag, out_word.buzzer_flag);
            mismatches++;
          end
          if (out_word.trouble_code !== want.trouble_code) begin
            $display("%0t: trouble_code expected %0d, got %0d",
                     $time, want.trouble_code, out_word.trouble_code);
            mismatches++;
          end
        end
      end
    end
    pending = predicted_words.size();
  end

endmodule

// ===== sim/trouble_flash_code_led_tb.sv =====
// Testbench top for the trouble flash-code LED block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module trouble_flash_code_led_tb;
  import tfc_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  flags_t           tick;
  logic             out_valid;
  logic             out_stall;
  logic             out_led_on;
  logic             out_buzzer_flag;
  logic [CodeW-1:0] out_trouble_code;
  logic             cfg_we;
  logic [IdxW-1:0]  cfg_index;
  logic [TimeW-1:0] cfg_data;

  int               mismatches;
  int               pending;
  int               words_taken;
  bit               idle_on;

  trouble_flash_code_led uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_any_trouble     (tick.any_trouble),
    .in_heat_det_one    (tick.heat_det_one),
    .in_heat_det_two    (tick.heat_det_two),
    .in_manual_switch   (tick.manual_switch),
    .in_actuator_fault  (tick.actuator_fault),
    .in_primary_power   (tick.primary_power),
    .in_secondary_power (tick.secondary_power),
    .in_pressure_switch (tick.pressure_switch),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_led_on         (out_led_on),
    .out_buzzer_flag    (out_buzzer_flag),
    .out_trouble_code   (out_trouble_code),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  flash_code_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (tick),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   ({out_led_on, out_buzzer_flag, out_trouble_code}),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("** trouble_flash_code_led: FAILED **");
    $finish;
  end

  // The receiver holds off for a long stretch twice so that the block fills and stalls its input.
  initial begin
    int hold;
    out_stall <= 1'b0;
    words_taken = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        words_taken++;
        if (words_taken == 300 || words_taken == 1500) hold = 60;
        else hold = idle_on ? $urandom_range(0, 4) : 0;
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic flags_t code_flags(input int code);
    return flags_t'(8'h80 | (8'h80 >> code));
  endfunction

  task automatic send_tick(input flags_t f);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_ticks(input int count);
    flags_t f;
    int     run;
    int     sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0:       f = flags_t'({1'b0, 7'($urandom)});
        1:       f = flags_t'(8'h80);
        2, 3:    f = flags_t'({1'b1, 7'($urandom)});
        default: f = code_flags($urandom_range(1, 7));
      endcase
      run = $urandom_range(1, 80);
      while (run > 0 && sent < count) begin
        if ($urandom_range(0, 15) == 0) send_tick(flags_t'(8'($urandom)));
        else send_tick(f);
        run--;
        sent++;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timings(input logic [TimeW-1:0] on_ms, gap_ms, pause_ms);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ON_TIME;
    cfg_data  <= on_ms;
    @(posedge clk);
    cfg_index <= REG_GAP_TIME;
    cfg_data  <= gap_ms;
    @(posedge clk);
    cfg_index <= REG_PAUSE_TIME;
    cfg_data  <= pause_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    tick      <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ON_TIME;
    cfg_data  <= '0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_ticks(200);
    drain();

    load_timings(16'd1, 16'd1, 16'd2);
    send_tick(flags_t'(8'h00));
    send_tick(flags_t'(8'h7F));
    send_tick(flags_t'(8'h80));
    for (int k = 1; k <= 7; k++) send_tick(code_flags(k));
    send_tick(flags_t'(8'hFF));
    repeat (6) send_tick(code_flags(7));
    // Drop to a lower code while the group is past it.
    repeat (3) send_tick(code_flags(2));
    send_tick(flags_t'(8'h80));
    send_tick(flags_t'(8'h00));
    random_ticks(250);
    drain();

    load_timings(16'd0, 16'd0, 16'd0);
    random_ticks(250);
    drain();

    load_timings(16'd1, 16'd1, 16'd1);
    random_ticks(250);
    drain();

    load_timings(16'd2, 16'd3, 16'd5);
    idle_on = 1'b0;
    random_ticks(250);
    drain();
    idle_on = 1'b1;

    load_timings(16'($urandom_range(20, 60)), 16'($urandom_range(20, 60)),
                 16'($urandom_range(20, 60)));
    random_ticks(250);
    drain();

    for (int p = 0; p < 2; p++) begin
      load_timings(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)));
      random_ticks(250);
      drain();
    end

    load_timings(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 8)));
    random_ticks(250);
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("** trouble_flash_code_led: PASSED **");
    end else begin
      $display("** trouble_flash_code_led: FAILED **");
    end
    $finish;
  end

endmodule
